>>> rtl/lcdnw_pkg.sv
// Types, codes and fixed tables for the character LCD nibble write sequencer.
// No dependencies; imported by char_lcd_nibble_write_sequencer.
`default_nettype none
package lcdnw_pkg;

	// Request kinds
	localparam logic [2:0] MODE_CMD    = 3'd0;
	localparam logic [2:0] MODE_DATA   = 3'd1;
	localparam logic [2:0] MODE_TEXT   = 3'd2;
	localparam logic [2:0] MODE_CURSOR = 3'd3;
	localparam logic [2:0] MODE_INIT   = 3'd4;

	localparam logic [7:0] PULSE_RESET   = 8'd5;
	localparam logic [3:0] INIT_LAST     = 4'd14;
	localparam logic [3:0] BYTE_LAST     = 4'd1;
	localparam logic [1:0] TEXT_HIGH_SEL = 2'b11;  // characters 192 and up

	typedef struct packed {
		logic [2:0] mode;
		logic [7:0] value;
		logic [5:0] column;
		logic       row;
	} req_t;

	typedef struct packed {
		logic       register_select;
		logic [3:0] nibble;
		logic [3:0] pre_wait_ms;
		logic [7:0] pulse_ms;
		logic       last_pulse;
	} rsp_t;

	// One queued job: a byte with its select level, or the power-up sequence
	typedef struct packed {
		logic       is_init;
		logic       rs;
		logic [7:0] data;
	} job_t;

	function automatic logic [7:0] cyr_map(input logic [5:0] idx);
		logic [7:0] r;
		unique case (idx)
			6'd0:  r = 8'h41; 6'd1:  r = 8'h80; 6'd2:  r = 8'h42; 6'd3:  r = 8'h81;
			6'd4:  r = 8'h82; 6'd5:  r = 8'h45; 6'd6:  r = 8'h83; 6'd7:  r = 8'h92;
			6'd8:  r = 8'h84; 6'd9:  r = 8'h85; 6'd10: r = 8'h4B; 6'd11: r = 8'h86;
			6'd12: r = 8'h4D; 6'd13: r = 8'h48; 6'd14: r = 8'h4F; 6'd15: r = 8'h87;
			6'd16: r = 8'h50; 6'd17: r = 8'h43; 6'd18: r = 8'h54; 6'd19: r = 8'h93;
			6'd20: r = 8'h88; 6'd21: r = 8'h58; 6'd22: r = 8'h89; 6'd23: r = 8'h8A;
			6'd24: r = 8'h8B; 6'd25: r = 8'h8C; 6'd26: r = 8'h8D; 6'd27: r = 8'h8E;
			6'd28: r = 8'h94; 6'd29: r = 8'h8F; 6'd30: r = 8'h90; 6'd31: r = 8'h91;
			6'd32: r = 8'h61; 6'd33: r = 8'hA0; 6'd34: r = 8'hB5; 6'd35: r = 8'hA1;
			6'd36: r = 8'hA2; 6'd37: r = 8'h65; 6'd38: r = 8'hA3; 6'd39: r = 8'hB2;
			6'd40: r = 8'hA4; 6'd41: r = 8'hA5; 6'd42: r = 8'hB6; 6'd43: r = 8'hA6;
			6'd44: r = 8'hB7; 6'd45: r = 8'hB8; 6'd46: r = 8'h6F; 6'd47: r = 8'hA7;
			6'd48: r = 8'h70; 6'd49: r = 8'h63; 6'd50: r = 8'hB9; 6'd51: r = 8'hB3;
			6'd52: r = 8'hA8; 6'd53: r = 8'h78; 6'd54: r = 8'hA9; 6'd55: r = 8'hAA;
			6'd56: r = 8'hAB; 6'd57: r = 8'hAC; 6'd58: r = 8'hAD; 6'd59: r = 8'hAE;
			6'd60: r = 8'hB4; 6'd61: r = 8'hAF; 6'd62: r = 8'hB0; 6'd63: r = 8'hB1;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] init_nib(input logic [3:0] step);
		logic [3:0] r;
		unique case (step)
			4'd0, 4'd2, 4'd4: r = 4'h3;
			4'd6, 4'd7:       r = 4'h2;
			4'd8:             r = 4'h8;
			4'd10:            r = 4'h1;
			4'd12:            r = 4'h6;
			4'd14:            r = 4'hC;
			default:          r = 4'h0;
		endcase
		return r;
	endfunction

	function automatic logic [3:0] init_wait(input logic [3:0] step);
		logic [3:0] r;
		unique case (step)
			4'd0:    r = 4'd15;
			4'd2:    r = 4'd5;
			4'd4:    r = 4'd1;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

>>> rtl/lcdnw_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none
module lcdnw_ram #(
	parameter int WIDTH = 10,
	parameter int DEPTH = 4
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/char_lcd_nibble_write_sequencer.sv
// Top level of the character LCD nibble write sequencer: request queue in RAM,
// read stage and pulse sequencer. Depends on lcdnw_pkg and lcdnw_ram.
//
//  channel  | ports                         | handshake
//  ---------+-------------------------------+-------------------------------
//  request  | start, busy, request          | taken when start & !busy
//  result   | strobe, result                | one cycle per pulse, no stall
//  config   | cfg_valid, cfg_ready, cfg_data| written when valid & ready
//
// One result (one enable pulse) leaves per clock. A byte request gives two
// pulses; initialisation gives fifteen. The sequencer is the limit: it emits
// one pulse per cycle from the job it holds while the next job already waits
// in the RAM read register.
// First pulse of a request on an empty block passes the queue RAM, its read
// register and the sequencer register before it is on the ports.
// Requests queue in a DEPTH-entry RAM; busy is high while it is full.
// Reset clears queue pointers, sequencer and pulse time (to 5 ms); queue
// contents are not cleared and need not be. The receiver cannot stall.
`default_nettype none
module char_lcd_nibble_write_sequencer #(
	parameter int DEPTH = 4
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	// request
	input  wire logic            start,
	output      logic            busy,
	input  wire lcdnw_pkg::req_t request,
	// result
	output      logic            strobe,
	output      lcdnw_pkg::rsp_t result,
	// configuration
	input  wire logic            cfg_valid,
	output      logic            cfg_ready,
	input  wire logic [7:0]      cfg_data
);
	import lcdnw_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int JW = $bits(job_t);

	// Configuration
	logic [7:0] pulse_ms_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_ms_q <= PULSE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			pulse_ms_q <= cfg_data;
		end
	end

	// Request decode: turn a request into one queued job
	logic take;
	logic job_ok;
	job_t job_in;

	assign take = start && !busy;

	always_comb begin
		job_ok = 1'b1;
		job_in = '0;
		unique case (request.mode)
			MODE_CMD: begin
				job_in.data = request.value;
			end
			MODE_DATA: begin
				job_in.rs   = 1'b1;
				job_in.data = request.value;
			end
			MODE_TEXT: begin
				job_in.rs   = 1'b1;
				job_in.data = (request.value[7:6] == TEXT_HIGH_SEL)
				              ? cyr_map(request.value[5:0]) : request.value;
			end
			MODE_CURSOR: begin
				// set DDRAM address: row picks bit 6, column fills bits 5:0
				job_in.data = {1'b1, request.row, request.column};
			end
			MODE_INIT: begin
				job_in.is_init = 1'b1;
			end
			default: begin
				job_ok = 1'b0;  // unused kinds are taken and dropped
			end
		endcase
	end

	// Queue pointers; a slot is read only once written, so the ports never clash
	logic [AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          wr_en, rd_en;
	logic          rd_valid_s1;
	logic          seq_free;
	job_t          job_s1;

	assign busy  = (count_q == CW'(DEPTH));
	assign wr_en = take && job_ok;
	assign rd_en = (count_q != '0) && (!rd_valid_s1 || seq_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q    <= '0;
			rd_ptr_q    <= '0;
			count_q     <= '0;
			rd_valid_s1 <= 1'b0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (rd_en) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			priority if (wr_en && !rd_en) begin
				count_q <= count_q + 1'b1;
			end else if (rd_en && !wr_en) begin
				count_q <= count_q - 1'b1;
			end else begin
				count_q <= count_q;
			end
			if (rd_en) begin
				rd_valid_s1 <= 1'b1;
			end else if (seq_free) begin
				rd_valid_s1 <= 1'b0;
			end
		end
	end

	lcdnw_ram #(
		.WIDTH (JW),
		.DEPTH (DEPTH)
	) u_queue (
		.clk   (clk),
		.we    (wr_en),
		.waddr (wr_ptr_q),
		.wdata (job_in),
		.re    (rd_en),
		.raddr (rd_ptr_q),
		.rdata (job_s1)
	);

	// Pulse sequencer: one pulse per cycle from the held job
	logic       active_q;
	logic [3:0] step_q;
	job_t       job_q;
	logic       last;

	assign last     = job_q.is_init ? (step_q == INIT_LAST) : (step_q == BYTE_LAST);
	assign seq_free = !active_q || last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			step_q   <= '0;
		end else begin
			priority if (rd_valid_s1 && seq_free) begin
				active_q <= 1'b1;
				step_q   <= '0;
			end else if (active_q && last) begin
				active_q <= 1'b0;
			end else if (active_q) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_valid_s1 && seq_free) begin
			job_q <= job_s1;
		end
	end

	// Result drive
	assign strobe = active_q;

	always_comb begin
		result.pulse_ms   = pulse_ms_q;
		result.last_pulse = last;
		if (job_q.is_init) begin
			result.register_select = 1'b0;
			result.nibble          = init_nib(step_q);
			result.pre_wait_ms     = init_wait(step_q);
		end else begin
			result.register_select = job_q.rs;
			result.nibble          = step_q[0] ? job_q.data[3:0] : job_q.data[7:4];
			result.pre_wait_ms     = '0;
		end
	end

endmodule
`default_nettype wire

>>> bench/lcdnw_pulse_checker.sv
// Pulse checker for the character LCD nibble write sequencer: watches the
// request, result and configuration channels, predicts every enable pulse and
// compares it. Depends on lcdnw_pkg for the request and result types.
module lcdnw_pulse_checker (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic            busy,
	input  lcdnw_pkg::req_t request,
	input  logic            strobe,
	input  lcdnw_pkg::rsp_t result,
	input  logic            cfg_valid,
	input  logic            cfg_ready,
	input  logic [7:0]      cfg_data,
	output int              failures,
	output int              outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	import lcdnw_pkg::*;

	// Display codes for characters 192..255 (Cyrillic page of the controller ROM)
	localparam logic [7:0] GLYPH_CODE [0:63] = '{
		8'h41, 8'h80, 8'h42, 8'h81, 8'h82, 8'h45, 8'h83, 8'h92,
		8'h84, 8'h85, 8'h4B, 8'h86, 8'h4D, 8'h48, 8'h4F, 8'h87,
		8'h50, 8'h43, 8'h54, 8'h93, 8'h88, 8'h58, 8'h89, 8'h8A,
		8'h8B, 8'h8C, 8'h8D, 8'h8E, 8'h94, 8'h8F, 8'h90, 8'h91,
		8'h61, 8'hA0, 8'hB5, 8'hA1, 8'hA2, 8'h65, 8'hA3, 8'hB2,
		8'hA4, 8'hA5, 8'hB6, 8'hA6, 8'hB7, 8'hB8, 8'h6F, 8'hA7,
		8'h70, 8'h63, 8'hB9, 8'hB3, 8'hA8, 8'h78, 8'hA9, 8'hAA,
		8'hAB, 8'hAC, 8'hAD, 8'hAE, 8'hB4, 8'hAF, 8'hB0, 8'hB1
	};

	// Power-up: 8-bit mode three times, 4-bit mode, function set, then
	// clear, entry mode and display on as nibble pairs
	localparam logic [3:0] POWER_UP_NIB [0:14] = '{
		4'h3, 4'h0, 4'h3, 4'h0, 4'h3, 4'h0, 4'h2, 4'h2,
		4'h8, 4'h0, 4'h1, 4'h0, 4'h6, 4'h0, 4'hC
	};
	localparam logic [3:0] POWER_UP_WAIT [0:14] = '{
		4'd15, 4'd0, 4'd5, 4'd0, 4'd1, 4'd0, 4'd0, 4'd0,
		4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0
	};
	localparam int POWER_UP_PULSES = 15;
	localparam logic [7:0] TEXT_MAP_FROM = 8'd192;
	localparam logic [7:0] SET_DDRAM     = 8'h80;
	localparam logic [7:0] LINE_TWO      = 8'h40;

	rsp_t       pending_pulses [$];
	logic [7:0] pulse_time;
	int         mismatch_count = 0;

	assign failures = mismatch_count;

	function automatic rsp_t make_pulse(logic rs, logic [3:0] nib, logic [3:0] wait_ms,
			logic last);
		rsp_t p;
		p.register_select = rs;
		p.nibble          = nib;
		p.pre_wait_ms     = wait_ms;
		p.pulse_ms        = pulse_time;
		p.last_pulse      = last;
		return p;
	endfunction

	task automatic queue_byte(logic rs, logic [7:0] b);
		pending_pulses.push_back(make_pulse(rs, b[7:4], 4'd0, 1'b0));
		pending_pulses.push_back(make_pulse(rs, b[3:0], 4'd0, 1'b1));
	endtask

	task automatic predict(req_t req);
		logic [7:0] ch;
		case (req.mode)
			MODE_CMD:  queue_byte(1'b0, req.value);
			MODE_DATA: queue_byte(1'b1, req.value);
			MODE_TEXT: begin
				ch = (req.value >= TEXT_MAP_FROM) ? GLYPH_CODE[req.value[5:0]] : req.value;
				queue_byte(1'b1, ch);
			end
			// column goes in as given, six bits cannot reach the line bit
			MODE_CURSOR: queue_byte(1'b0,
				SET_DDRAM | (req.row ? LINE_TWO : 8'h00) | {2'b00, req.column});
			MODE_INIT: begin
				for (int i = 0; i < POWER_UP_PULSES; i++)
					pending_pulses.push_back(make_pulse(1'b0, POWER_UP_NIB[i],
						POWER_UP_WAIT[i], i == POWER_UP_PULSES - 1));
			end
			default: ;  // unused kinds give nothing
		endcase
	endtask

	task automatic compare_pulse(rsp_t want, rsp_t got);
		if (got.register_select !== want.register_select) begin
			$error("register_select: expected %0h, got %0h", want.register_select,
				got.register_select);
			mismatch_count++;
		end
		if (got.nibble !== want.nibble) begin
			$error("nibble: expected %0h, got %0h", want.nibble, got.nibble);
			mismatch_count++;
		end
		if (got.pre_wait_ms !== want.pre_wait_ms) begin
			$error("pre_wait_ms: expected %0d, got %0d", want.pre_wait_ms, got.pre_wait_ms);
			mismatch_count++;
		end
		if (got.pulse_ms !== want.pulse_ms) begin
			$error("pulse_ms: expected %0d, got %0d", want.pulse_ms, got.pulse_ms);
			mismatch_count++;
		end
		if (got.last_pulse !== want.last_pulse) begin
			$error("last_pulse: expected %0h, got %0h", want.last_pulse, got.last_pulse);
			mismatch_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pulse_time = PULSE_RESET;
			pending_pulses.delete();
			outstanding <= 0;
		end else begin
			if (strobe === 1'b1) begin
				if (pending_pulses.size() == 0) begin
					$error("pulse with no request outstanding: nibble %0h", result.nibble);
					mismatch_count++;
				end else begin
					compare_pulse(pending_pulses.pop_front(), result);
				end
			end
			if (cfg_valid && cfg_ready)
				pulse_time = cfg_data;
			if (start && !busy)
				predict(request);
			outstanding <= pending_pulses.size();
		end
	end

endmodule

>>> bench/char_lcd_nibble_write_sequencer_tb.sv
// Top of the nibble write sequencer bench: clock, reset, request and pulse
// time stimulus, verdict. Depends on lcdnw_pkg, the block and lcdnw_pulse_checker.
module char_lcd_nibble_write_sequencer_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import lcdnw_pkg::*;

	// unused request kinds, which the block must swallow silently
	localparam logic [2:0] MODE_UNUSED_LO = 3'd5;
	localparam logic [2:0] MODE_UNUSED_HI = 3'd7;

	localparam int PHASE_REQUESTS = 70;
	// margin for the last pulse to clear the ports before the pulse time changes
	localparam int SETTLE_CYCLES  = 24;
	// the limit covers the slowest run: ~370 requests, each up to 15
	// pulses plus the longest sender gap, plus drains between phases
	localparam int CYCLE_LIMIT    = 400000;

	logic       clk;
	logic       arst_n;
	logic       start;
	logic       busy;
	req_t       request;
	logic       strobe;
	rsp_t       result;
	logic       cfg_valid;
	logic       cfg_ready;
	logic [7:0] cfg_data;

	int         failures;
	int         outstanding;
	bit         no_idle;

	char_lcd_nibble_write_sequencer dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.request   (request),
		.strobe    (strobe),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	lcdnw_pulse_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.request     (request),
		.strobe      (strobe),
		.result      (result),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data),
		.failures    (failures),
		.outstanding (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost pulse ends up here
	initial begin : watchdog
		int unsigned cycle_count;
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	function automatic req_t make_req(logic [2:0] mode, logic [7:0] value,
			logic [5:0] column, logic row);
		req_t r;
		r.mode   = mode;
		r.value  = value;
		r.column = column;
		r.row    = row;
		return r;
	endfunction

	// Mostly short gaps, now and then a long one so pauses land mid-sequence
	function automatic int unsigned idle_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 55)
			return 0;
		if (roll < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Byte kinds dominate; power-up and unused kinds are sprinkled in.
	// All fields are random whatever the kind, so unused fields toggle too.
	function automatic req_t random_request();
		req_t        r;
		int unsigned roll;
		r = make_req(3'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
			6'($urandom_range(0, 63)), 1'($urandom_range(0, 1)));
		roll = $urandom_range(0, 99);
		if (roll < 22)
			r.mode = MODE_CMD;
		else if (roll < 42)
			r.mode = MODE_DATA;
		else if (roll < 68) begin
			r.mode = MODE_TEXT;
			if ($urandom_range(0, 1))
				r.value = 8'($urandom_range(192, 255));  // codepage half
		end else if (roll < 90) begin
			r.mode = MODE_CURSOR;
			// mostly real columns, sometimes past the end of the line
			r.column = ($urandom_range(0, 99) < 85) ? 6'($urandom_range(0, 39))
				: 6'($urandom_range(40, 63));
		end else if (roll < 95)
			r.mode = MODE_INIT;
		else
			r.mode = 3'($urandom_range(MODE_UNUSED_LO, MODE_UNUSED_HI));
		return r;
	endfunction

	// Hold start until the request is taken; start stays high when the next
	// request follows straight on, so it is never dropped and raised in one step
	task automatic send_request(input req_t req);
		int unsigned gap;
		gap = no_idle ? 0 : idle_gap();
		start   <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stop sending and let every predicted pulse come out
	task automatic wait_idle();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_pulse_time(input logic [7:0] ms);
		cfg_valid <= 1'b1;
		cfg_data  <= ms;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	initial begin : stimulus
		logic [7:0] pulse_settings [5];
		arst_n    = 1'b0;
		start     = 1'b0;
		request   = '0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		no_idle   = 1'b0;
		// both extremes, the zero corner, one random value, back to reset value
		pulse_settings = '{8'd1, 8'd255, 8'd0, 8'($urandom_range(2, 254)), PULSE_RESET};

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests at the reset pulse time
		send_request(make_req(MODE_CMD,    8'h00, 6'd0,  1'b0));
		send_request(make_req(MODE_CMD,    8'hFF, 6'd63, 1'b1));
		send_request(make_req(MODE_DATA,   8'h00, 6'd0,  1'b0));
		send_request(make_req(MODE_DATA,   8'hFF, 6'd63, 1'b1));
		send_request(make_req(MODE_TEXT,   8'h00, 6'd0,  1'b0));  // NUL is sent, not a terminator
		send_request(make_req(MODE_TEXT,   8'd191, 6'd0, 1'b0));  // last unmapped char
		send_request(make_req(MODE_TEXT,   8'd192, 6'd0, 1'b0));  // first codepage entry
		send_request(make_req(MODE_TEXT,   8'd255, 6'd0, 1'b0));  // last codepage entry
		send_request(make_req(MODE_TEXT,   8'd226, 6'd0, 1'b0));
		send_request(make_req(MODE_CURSOR, 8'h00, 6'd0,  1'b0));
		send_request(make_req(MODE_CURSOR, 8'h00, 6'd39, 1'b1));
		send_request(make_req(MODE_CURSOR, 8'h00, 6'd40, 1'b0));  // past line end
		send_request(make_req(MODE_CURSOR, 8'hFF, 6'd63, 1'b0));  // must not reach line bit
		send_request(make_req(MODE_CURSOR, 8'hFF, 6'd63, 1'b1));
		send_request(make_req(MODE_INIT,   8'h00, 6'd0,  1'b0));
		send_request(make_req(3'd5,        8'hA5, 6'd21, 1'b1));
		send_request(make_req(3'd6,        8'h5A, 6'd42, 1'b0));
		send_request(make_req(MODE_UNUSED_HI, 8'hFF, 6'd63, 1'b1));
		send_request(make_req(MODE_INIT,   8'hFF, 6'd63, 1'b1));
		send_request(make_req(MODE_DATA,   8'h3C, 6'd0,  1'b0));

		// Random phases, one per pulse time; the drain before each write is
		// also the full pause the sender makes while pulses are in flight
		foreach (pulse_settings[p]) begin
			wait_idle();
			write_pulse_time(pulse_settings[p]);
			no_idle = (p == 1);  // one phase back to back, no sender gaps
			for (int n = 0; n < PHASE_REQUESTS; n++)
				send_request(random_request());
		end

		wait_idle();
		if (failures == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
